### rtl/bitvector_alu_smtlib_top_macros.svh
// assertion macros for the bit-vector alu
`ifndef BITVECTOR_ALU_SMTLIB_TOP_MACROS_SVH
`define BITVECTOR_ALU_SMTLIB_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked while out of reset
`define BVALU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define BVALU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BVALU_ASSERT(lbl, prop, msg)
`define BVALU_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/bvalu_pkg.sv
// package: opcodes and beat types of the bit-vector alu
package bvalu_pkg;

  localparam int DEF_WIDTH = 32;
  localparam int FIELD_W   = 32;
  localparam int MODE_W    = 6;

  typedef enum logic [MODE_W-1:0] {
    OP_NOT = 6'd0, OP_AND = 6'd1, OP_OR = 6'd2, OP_XOR = 6'd3, OP_NAND = 6'd4,
    OP_NOR = 6'd5, OP_XNOR = 6'd6, OP_REDAND = 6'd7, OP_REDOR = 6'd8,
    OP_NEG = 6'd9, OP_ADD = 6'd10, OP_SUB = 6'd11, OP_MUL = 6'd12,
    OP_UDIV = 6'd13, OP_UREM = 6'd14, OP_SDIV = 6'd15, OP_SREM = 6'd16,
    OP_SMOD = 6'd17, OP_SHL = 6'd18, OP_LSHR = 6'd19, OP_ASHR = 6'd20,
    OP_ROTL = 6'd21, OP_ROTR = 6'd22, OP_ULT = 6'd23, OP_ULE = 6'd24,
    OP_UGE = 6'd25, OP_UGT = 6'd26, OP_EQ = 6'd27, OP_SLT = 6'd28,
    OP_SLE = 6'd29, OP_SGE = 6'd30, OP_SGT = 6'd31, OP_NEGO = 6'd32,
    OP_UADDO = 6'd33, OP_SADDO = 6'd34, OP_UMULO = 6'd35, OP_SMULO = 6'd36,
    OP_USUBO = 6'd37, OP_SSUBO = 6'd38, OP_SDIVO = 6'd39
  } op_e;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [FIELD_W-1:0] operand_a;
    logic [FIELD_W-1:0] operand_b;
  } in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] result_value;
    logic               result_flag;
  } out_t;

endpackage

### rtl/bitvector_alu_smtlib_top.sv
// top level: pipelined bit-vector alu with smt-lib division and overflow rules
// an accepted input beat moves through every stage register, st_r[0] to st_r[N], to its output beat
// throughput: one beat per cycle while out_ready holds; the restoring divider takes one quotient bit per stage
// rotates reduce b mod WIDTH in the same divider stages
// reset (rst_n low, synchronous) empties every stage; no other state
`include "bitvector_alu_smtlib_top_macros.svh"
module bitvector_alu_smtlib_top #(
  parameter int WIDTH = bvalu_pkg::DEF_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  bvalu_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output bvalu_pkg::out_t  out_data
);
  import bvalu_pkg::*;

  localparam int W  = WIDTH;
  localparam int N  = W + 2;   // index of the last stage
  localparam int HW = 32;      // partial product half width
  localparam logic [W-1:0] SBIT = W'(64'd1 << (W - 1));
  localparam logic [W-1:0] ONES = '1;

  typedef struct packed {
    logic [MODE_W-1:0] op;
    logic              sa;
    logic              sb;
    logic              mneg;
    logic [W-1:0]      a;
    logic [W-1:0]      b;
    logic [W-1:0]      val;
    logic              flag;
    logic [W-1:0]      rem;
    logic [W-1:0]      quo;
    logic [W-1:0]      dvs;
    logic [2*HW-1:0]   pp00;
    logic [2*HW-1:0]   pp01;
    logic [2*HW-1:0]   pp10;
    logic [2*HW-1:0]   pp11;
    logic [2*W-1:0]    prod;
  } rec_t;

  // stage 1: simple ops, divider and multiplier setup
  function automatic rec_t pre_stage(rec_t r);
    rec_t          o;
    logic [W-1:0]  ma, mb, t, x, y;
    logic [63:0]   x64, y64;
    logic          sig;
    o = r;
    o.sa = r.a[W-1];
    o.sb = r.b[W-1];
    o.val = '0;
    o.flag = 1'b0;
    ma = o.sa ? (W'(0) - r.a) : r.a;
    mb = o.sb ? (W'(0) - r.b) : r.b;
    o.mneg = o.sa ^ o.sb;
    sig = (r.op == OP_SDIV) || (r.op == OP_SREM) || (r.op == OP_SMOD);
    // divider operands; rotates reduce b mod WIDTH in the divider
    o.rem = '0;
    if ((r.op == OP_ROTL) || (r.op == OP_ROTR)) begin
      o.quo = r.b;
      o.dvs = W'(W);
    end else begin
      o.quo = sig ? ma : r.a;
      o.dvs = sig ? mb : r.b;
    end
    // multiplier operands and partial products
    x = (r.op == OP_UMULO) ? r.a : ma;
    y = (r.op == OP_UMULO) ? r.b : mb;
    x64 = 64'(x);
    y64 = 64'(y);
    o.pp00 = x64[31:0] * y64[31:0];
    o.pp01 = x64[31:0] * y64[63:32];
    o.pp10 = x64[63:32] * y64[31:0];
    o.pp11 = x64[63:32] * y64[63:32];
    o.prod = '0;
    case (r.op)
      OP_NOT:    o.val = ~r.a;
      OP_AND:    o.val = r.a & r.b;
      OP_OR:     o.val = r.a | r.b;
      OP_XOR:    o.val = r.a ^ r.b;
      OP_NAND:   o.val = ~(r.a & r.b);
      OP_NOR:    o.val = ~(r.a | r.b);
      OP_XNOR:   o.val = ~(r.a ^ r.b);
      OP_REDAND: o.flag = (r.a == ONES);
      OP_REDOR:  o.flag = (r.a != '0);
      OP_NEG:    o.val = W'(0) - r.a;
      OP_ADD:    o.val = r.a + r.b;
      OP_SUB:    o.val = r.a - r.b;
      OP_SHL:    o.val = (r.b >= W) ? '0 : (r.a << r.b);
      OP_LSHR:   o.val = (r.b >= W) ? '0 : (r.a >> r.b);
      OP_ASHR:   o.val = (r.b >= W) ? (o.sa ? ONES : '0) : W'($signed(r.a) >>> r.b);
      OP_ULT:    o.flag = r.a < r.b;
      OP_ULE:    o.flag = r.a <= r.b;
      OP_UGE:    o.flag = r.a >= r.b;
      OP_UGT:    o.flag = r.a > r.b;
      OP_EQ:     o.flag = r.a == r.b;
      OP_SLT:    o.flag = $signed(r.a) < $signed(r.b);
      OP_SLE:    o.flag = $signed(r.a) <= $signed(r.b);
      OP_SGE:    o.flag = $signed(r.a) >= $signed(r.b);
      OP_SGT:    o.flag = $signed(r.a) > $signed(r.b);
      OP_NEGO:   o.flag = (r.a == SBIT);
      OP_UADDO: begin
        t = r.a + r.b;
        o.flag = t < r.a;
      end
      OP_SADDO: begin
        t = r.a + r.b;
        o.flag = (o.sa == o.sb) && (t[W-1] != o.sa);
      end
      OP_USUBO:  o.flag = r.a < r.b;
      OP_SSUBO: begin
        t = r.a - r.b;
        o.flag = (o.sa != o.sb) && (t[W-1] != o.sa);
      end
      OP_SDIVO:  o.flag = (r.a == SBIT) && (r.b == ONES);
      default: begin
        o.val = '0;
        o.flag = 1'b0;
      end
    endcase
    return o;
  endfunction

  // one restoring divider step: one quotient bit
  function automatic rec_t div_step(rec_t r);
    rec_t        o;
    logic [W:0]  sh;
    logic        ge;
    o = r;
    sh = {r.rem, r.quo[W-1]};
    ge = sh >= {1'b0, r.dvs};
    o.rem = ge ? W'(sh - {1'b0, r.dvs}) : sh[W-1:0];
    o.quo = (r.quo << 1) | W'(ge);
    return o;
  endfunction

  // sum of the partial products
  function automatic rec_t mul_sum(rec_t r);
    rec_t          o;
    logic [127:0]  s;
    o = r;
    s = 128'(r.pp00) + (128'(r.pp01) << HW) + (128'(r.pp10) << HW) + (128'(r.pp11) << (2 * HW));
    o.prod = s[2*W-1:0];
    return o;
  endfunction

  // multiply result and overflow flags
  function automatic rec_t mul_flags(rec_t r);
    rec_t          o;
    logic [W-1:0]  lo, hi;
    o = r;
    lo = r.prod[W-1:0];
    hi = r.prod[2*W-1:W];
    case (r.op)
      OP_MUL:   o.val = r.mneg ? (W'(0) - lo) : lo;
      OP_UMULO: o.flag = (hi != '0);
      OP_SMULO: o.flag = (hi != '0) || (r.mneg ? (lo > SBIT) : (lo > (SBIT - W'(1))));
      default:  o = r;
    endcase
    return o;
  endfunction

  // divider sign fixes and rotates
  function automatic rec_t finish(rec_t r);
    rec_t          o;
    logic [W-1:0]  t;
    o = r;
    t = r.sa ? (W'(0) - r.rem) : r.rem;
    case (r.op)
      OP_UDIV: o.val = r.quo;
      OP_UREM: o.val = r.rem;
      OP_SDIV: o.val = r.mneg ? (W'(0) - r.quo) : r.quo;
      OP_SREM: o.val = t;
      OP_SMOD: o.val = ((t != '0) && (t[W-1] != r.sb)) ? (t + r.b) : t;
      OP_ROTL: o.val = (r.rem == '0) ? r.a : ((r.a << r.rem) | (r.a >> (W'(W) - r.rem)));
      OP_ROTR: o.val = (r.rem == '0) ? r.a : ((r.a >> r.rem) | (r.a << (W'(W) - r.rem)));
      default: o = r;
    endcase
    return o;
  endfunction

  rec_t        st_r   [0:N];
  rec_t        st_nxt [0:N];
  logic [N:0]  v_r;
  logic [N:0]  en;
  rec_t        in_rec;
  logic [63:0] a_ext, b_ext, v_ext;

  // input beat to stage record
  always_comb begin
    a_ext = 64'(in_data.operand_a);
    b_ext = 64'(in_data.operand_b);
    in_rec = '0;
    in_rec.op = in_data.mode;
    in_rec.a = a_ext[W-1:0];
    in_rec.b = b_ext[W-1:0];
  end

  // stage enables: a stage moves when empty or when the next one moves
  always_comb begin
    en[N] = !v_r[N] || out_ready;
    for (int k = N - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready = en[0];
  assign st_nxt[0] = in_rec;

  // per-stage logic
  for (genvar k = 1; k <= N; k++) begin : g_stage
    always_comb begin
      st_nxt[k] = st_r[k-1];
      if (k == 1) st_nxt[k] = pre_stage(st_nxt[k]);
      if ((k >= 2) && (k <= W + 1)) st_nxt[k] = div_step(st_nxt[k]);
      if (k == 2) st_nxt[k] = mul_sum(st_nxt[k]);
      if (k == 3) st_nxt[k] = mul_flags(st_nxt[k]);
      if (k == N) st_nxt[k] = finish(st_nxt[k]);
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k <= N; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= N; k++) begin
      if (en[k]) st_r[k] <= st_nxt[k];
    end
  end

  // output beat
  assign out_valid = v_r[N];
  assign v_ext = 64'(st_r[N].val);
  assign out_data.result_value = v_ext[FIELD_W-1:0];
  assign out_data.result_flag = st_r[N].flag;

  `BVALU_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "output valid right after reset")
  `BVALU_ASSERT(a_stall_full, !in_ready |-> ((&v_r) && !out_ready), "input stalled with a bubble")
  `BVALU_ASSERT(a_udiv_zero, (out_valid && (st_r[N].op == OP_UDIV) && (st_r[N].dvs == '0)) |-> (st_r[N].val == ONES), "udiv by zero not all ones")

endmodule
